// ===== design/owo_pkg.sv =====
// Shared types, command codes and constants for the omni wheel odometry unit.
package owo_pkg;

  localparam int MulSelW = 4;
  localparam logic [MulSelW-1:0] MUL_SUM_GAIN = 4'd0;
  localparam logic [MulSelW-1:0] MUL_EX_C     = 4'd1;
  localparam logic [MulSelW-1:0] MUL_EY_S     = 4'd2;
  localparam logic [MulSelW-1:0] MUL_EX_S     = 4'd3;
  localparam logic [MulSelW-1:0] MUL_EY_C     = 4'd4;
  localparam logic [MulSelW-1:0] MUL_VX_C     = 4'd5;
  localparam logic [MulSelW-1:0] MUL_VY_S     = 4'd6;
  localparam logic [MulSelW-1:0] MUL_VX_S     = 4'd7;
  localparam logic [MulSelW-1:0] MUL_VY_C     = 4'd8;
  localparam logic [MulSelW-1:0] MUL_ACC_K    = 4'd9;
  localparam logic [MulSelW-1:0] MUL_RV_K     = 4'd10;

  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  localparam int WrW = 4;
  localparam logic [WrW-1:0] WR_NONE = 4'd0;
  localparam logic [WrW-1:0] WR_HEAD = 4'd1;
  localparam logic [WrW-1:0] WR_SIN  = 4'd2;
  localparam logic [WrW-1:0] WR_COS  = 4'd3;
  localparam logic [WrW-1:0] WR_PX   = 4'd4;
  localparam logic [WrW-1:0] WR_PY   = 4'd5;
  localparam logic [WrW-1:0] WR_RV   = 4'd6;
  localparam logic [WrW-1:0] WR_KY   = 4'd7;
  localparam logic [WrW-1:0] WR_KX   = 4'd8;
  localparam logic [WrW-1:0] WR_GOAL = 4'd9;
  localparam logic [WrW-1:0] WR_OUT  = 4'd10;

  typedef struct packed {
    logic               latch;
    logic [MulSelW-1:0] mul_sel;
    logic [1:0]         acc_op;
    logic [WrW-1:0]     wr;
    logic [1:0]         wheel;
  } cmd_t;

  localparam logic [23:0] AngleGainReset = 24'd547724;
  localparam logic [16:0] HeadingReset   = 17'd32768;
  localparam logic signed [25:0] InvSqrt2Q16 = 26'sd46341;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Quarter-wave sine entry in Q16 from an angle in Q30 radians
  function automatic logic [16:0] sine_q16(input logic [63:0] x);
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] r;
    term = x;
    sum = $signed(x);
    for (int n = 1; n < 24; n++) begin
      if (term != 64'd0) begin
        term = ((((term * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
    end
    if (sum < 0) sum = 64'sd0;
    r = (64'(sum) + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[16:0];
  endfunction

endpackage

// ===== design/owo_ctrl.sv =====
// Sequencer for one item: issues datapath commands and runs both handshakes.
module owo_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output owo_pkg::cmd_t cmd
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_DTH  = 5'd1;
  localparam logic [4:0] ST_HEAD = 5'd2;
  localparam logic [4:0] ST_SIN  = 5'd3;
  localparam logic [4:0] ST_COS  = 5'd4;
  localparam logic [4:0] ST_P0   = 5'd5;
  localparam logic [4:0] ST_P1   = 5'd6;
  localparam logic [4:0] ST_P2   = 5'd7;
  localparam logic [4:0] ST_P3   = 5'd8;
  localparam logic [4:0] ST_P4   = 5'd9;
  localparam logic [4:0] ST_V0   = 5'd10;
  localparam logic [4:0] ST_V1   = 5'd11;
  localparam logic [4:0] ST_V2   = 5'd12;
  localparam logic [4:0] ST_V3   = 5'd13;
  localparam logic [4:0] ST_K0   = 5'd14;
  localparam logic [4:0] ST_K1   = 5'd15;
  localparam logic [4:0] ST_G0   = 5'd16;
  localparam logic [4:0] ST_G1   = 5'd17;
  localparam logic [4:0] ST_G2   = 5'd18;
  localparam logic [4:0] ST_G3   = 5'd19;
  localparam logic [4:0] ST_DONE = 5'd20;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       fire_out;

  assign in_ready = (state == ST_IDLE);
  assign fire_out = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    cmd = '0;
    cmd.mul_sel = owo_pkg::MUL_SUM_GAIN;
    cmd.acc_op = owo_pkg::ACC_HOLD;
    cmd.wr = owo_pkg::WR_NONE;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) state_next = ST_DTH;
      end
      ST_DTH: begin
        state_next = ST_HEAD;
      end
      ST_HEAD: begin
        cmd.wr = owo_pkg::WR_HEAD;
        state_next = ST_SIN;
      end
      ST_SIN: begin
        cmd.wr = owo_pkg::WR_SIN;
        state_next = ST_COS;
      end
      ST_COS: begin
        cmd.wr = owo_pkg::WR_COS;
        state_next = ST_P0;
      end
      ST_P0: begin
        cmd.mul_sel = owo_pkg::MUL_EX_C;
        state_next = ST_P1;
      end
      ST_P1: begin
        cmd.mul_sel = owo_pkg::MUL_EY_S;
        cmd.acc_op = owo_pkg::ACC_LOAD;
        state_next = ST_P2;
      end
      ST_P2: begin
        cmd.mul_sel = owo_pkg::MUL_EX_S;
        cmd.acc_op = owo_pkg::ACC_SUB;
        state_next = ST_P3;
      end
      ST_P3: begin
        cmd.mul_sel = owo_pkg::MUL_EY_C;
        cmd.acc_op = owo_pkg::ACC_LOAD;
        cmd.wr = owo_pkg::WR_PX;
        state_next = ST_P4;
      end
      ST_P4: begin
        cmd.mul_sel = owo_pkg::MUL_VX_C;
        cmd.acc_op = owo_pkg::ACC_ADD;
        state_next = ST_V0;
      end
      ST_V0: begin
        cmd.mul_sel = owo_pkg::MUL_VY_S;
        cmd.acc_op = owo_pkg::ACC_LOAD;
        cmd.wr = owo_pkg::WR_PY;
        state_next = ST_V1;
      end
      ST_V1: begin
        cmd.mul_sel = owo_pkg::MUL_VX_S;
        cmd.acc_op = owo_pkg::ACC_SUB;
        state_next = ST_V2;
      end
      ST_V2: begin
        cmd.mul_sel = owo_pkg::MUL_VY_C;
        cmd.acc_op = owo_pkg::ACC_LOAD;
        cmd.wr = owo_pkg::WR_RV;
        state_next = ST_V3;
      end
      ST_V3: begin
        cmd.acc_op = owo_pkg::ACC_ADD;
        state_next = ST_K0;
      end
      ST_K0: begin
        cmd.mul_sel = owo_pkg::MUL_ACC_K;
        state_next = ST_K1;
      end
      ST_K1: begin
        cmd.mul_sel = owo_pkg::MUL_RV_K;
        cmd.wr = owo_pkg::WR_KY;
        state_next = ST_G0;
      end
      ST_G0: begin
        cmd.wr = owo_pkg::WR_KX;
        state_next = ST_G1;
      end
      ST_G1: begin
        cmd.wr = owo_pkg::WR_GOAL;
        cmd.wheel = 2'd0;
        state_next = ST_G2;
      end
      ST_G2: begin
        cmd.wr = owo_pkg::WR_GOAL;
        cmd.wheel = 2'd1;
        state_next = ST_G3;
      end
      ST_G3: begin
        cmd.wr = owo_pkg::WR_GOAL;
        cmd.wheel = 2'd2;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.wr = owo_pkg::WR_GOAL;
        cmd.wheel = 2'd3;
        if (fire_out) begin
          cmd.wr = owo_pkg::WR_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/owo_dp.sv =====
// Datapath: shared multiplier, accumulator, sine table, pose and goal registers.
module owo_dp #(
  parameter int SineTableDepth = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  owo_pkg::cmd_t       cmd,
  input  logic                cfg_wr_en,
  input  logic [23:0]         cfg_wr_data,
  input  logic                func,
  input  logic signed [23:0]  wheel_delta_0,
  input  logic signed [23:0]  wheel_delta_1,
  input  logic signed [23:0]  wheel_delta_2,
  input  logic signed [23:0]  wheel_delta_3,
  input  logic signed [23:0]  goal_vx,
  input  logic signed [23:0]  goal_vy,
  input  logic signed [23:0]  goal_wz,
  input  logic                stop,
  input  logic signed [31:0]  new_x,
  input  logic signed [31:0]  new_y,
  input  logic signed [16:0]  new_heading,
  output logic signed [31:0]  pose_x_out,
  output logic signed [31:0]  pose_y_out,
  output logic signed [16:0]  heading_out,
  output logic signed [23:0]  wheel_goal_0,
  output logic signed [23:0]  wheel_goal_1,
  output logic signed [23:0]  wheel_goal_2,
  output logic signed [23:0]  wheel_goal_3
);

  localparam int IdxW = $clog2(SineTableDepth + 1);
  localparam int MulW = 26 + IdxW;

  logic [16:0] tbl [0:SineTableDepth];

  for (genvar k = 0; k <= SineTableDepth; k++) begin : g_tbl
    localparam logic [63:0] XK = owo_pkg::HalfPiQ30 * 64'(k) / 64'(SineTableDepth);
    assign tbl[k] = owo_pkg::sine_q16(XK);
  end

  logic [23:0]        angle_gain;
  logic               func_q;
  logic               stop_q;
  logic signed [26:0] dsum;
  logic signed [24:0] ex;
  logic signed [24:0] ey;
  logic signed [23:0] vx;
  logic signed [23:0] vy;
  logic signed [23:0] wz;
  logic signed [31:0] nx;
  logic signed [31:0] ny;
  logic [15:0]        nh;

  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [16:0] heading;
  logic signed [17:0] sin_v;
  logic signed [17:0] cos_v;
  logic signed [59:0] prod;
  logic signed [43:0] acc;
  logic signed [41:0] rv;
  logic signed [59:0] kx;
  logic signed [59:0] ky;
  logic signed [23:0] goal [0:3];

  logic signed [43:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [69:0] mul_p;

  always_comb begin
    mul_a = 44'(dsum);
    mul_b = $signed({1'b0, angle_gain, 1'b0}) >>> 1;
    case (cmd.mul_sel)
      owo_pkg::MUL_SUM_GAIN: begin
        mul_a = 44'(dsum);
        mul_b = 26'($signed({1'b0, angle_gain}));
      end
      owo_pkg::MUL_EX_C: begin mul_a = 44'(ex); mul_b = 26'(cos_v); end
      owo_pkg::MUL_EY_S: begin mul_a = 44'(ey); mul_b = 26'(sin_v); end
      owo_pkg::MUL_EX_S: begin mul_a = 44'(ex); mul_b = 26'(sin_v); end
      owo_pkg::MUL_EY_C: begin mul_a = 44'(ey); mul_b = 26'(cos_v); end
      owo_pkg::MUL_VX_C: begin mul_a = 44'(vx); mul_b = 26'(cos_v); end
      owo_pkg::MUL_VY_S: begin mul_a = 44'(vy); mul_b = 26'(sin_v); end
      owo_pkg::MUL_VX_S: begin mul_a = 44'(vx); mul_b = 26'(sin_v); end
      owo_pkg::MUL_VY_C: begin mul_a = 44'(vy); mul_b = 26'(cos_v); end
      owo_pkg::MUL_ACC_K: begin mul_a = acc; mul_b = owo_pkg::InvSqrt2Q16; end
      owo_pkg::MUL_RV_K: begin mul_a = 44'(rv); mul_b = owo_pkg::InvSqrt2Q16; end
      default: begin mul_a = 44'(dsum); mul_b = 26'sd0; end
    endcase
    mul_p = 70'(mul_a) * 70'(mul_b);
  end

  // heading step and wrap into (-pi, pi]
  logic signed [59:0] dth_r;
  logic [15:0]        h_u;
  logic [15:0]        h_src;
  logic signed [16:0] h_wrap;

  assign dth_r = prod + 60'sd8388608;
  assign h_src = func_q ? nh : (heading[15:0] + dth_r[39:24]);
  assign h_u = h_src;
  assign h_wrap = (h_u > 16'd32768) ? $signed({1'b1, h_u}) : $signed({1'b0, h_u});

  // quarter-wave lookup
  logic [15:0]                  ang;
  logic [13:0]                  ofs;
  logic [14 + IdxW - 1:0]       ofs_scaled;
  logic [IdxW-1:0]              ti;
  logic [IdxW-1:0]              tidx;
  logic signed [17:0]           tval;

  assign ang = (cmd.wr == owo_pkg::WR_COS) ? (heading[15:0] + 16'd16384) : heading[15:0];
  assign ofs = ang[13:0];
  assign ofs_scaled = (14 + IdxW)'(ofs) * (14 + IdxW)'(SineTableDepth);
  assign ti = ofs_scaled[14 +: IdxW];
  assign tidx = ang[14] ? (IdxW'(SineTableDepth) - ti) : ti;
  assign tval = ang[15] ? -$signed({1'b0, tbl[tidx]}) : $signed({1'b0, tbl[tidx]});

  // pose update with rounding and saturation
  logic signed [43:0] acc_r;
  logic signed [32:0] pose_sum;
  logic signed [32:0] pose_base;
  logic signed [31:0] pose_sat;

  assign acc_r = acc + 44'sd65536;
  assign pose_base = (cmd.wr == owo_pkg::WR_PX) ? 33'(pose_x) : 33'(pose_y);
  assign pose_sum = pose_base + 33'($signed(acc_r[43:17]));
  assign pose_sat = (pose_sum > 33'sd2147483647) ? 32'sh7fffffff :
                    (pose_sum < -33'sd2147483648) ? 32'sh80000000 : pose_sum[31:0];

  // wheel goal mixing
  logic signed [61:0] w_kx;
  logic signed [61:0] w_ky;
  logic signed [61:0] w_sum;
  logic signed [29:0] w_rnd;
  logic signed [23:0] w_sat;

  always_comb begin
    w_kx = 62'(kx);
    w_ky = 62'(ky);
    case (cmd.wheel)
      2'd0: w_sum = w_kx - w_ky;
      2'd1: w_sum = -w_kx - w_ky;
      2'd2: w_sum = -w_kx + w_ky;
      default: w_sum = w_kx + w_ky;
    endcase
    w_sum = w_sum - 62'($signed({wz, 32'd0})) + 62'sd2147483648;
    w_rnd = w_sum[61:32];
    if (w_rnd > 30'sd8388607) w_sat = 24'sh7fffff;
    else if (w_rnd < -30'sd8388608) w_sat = 24'sh800000;
    else w_sat = w_rnd[23:0];
    if (stop_q) w_sat = 24'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_gain <= owo_pkg::AngleGainReset;
      pose_x <= 32'sd0;
      pose_y <= 32'sd0;
      heading <= owo_pkg::HeadingReset;
    end else begin
      if (cfg_wr_en) angle_gain <= cfg_wr_data;
      if (cmd.wr == owo_pkg::WR_HEAD) begin
        heading <= h_wrap;
        if (func_q) begin
          pose_x <= nx;
          pose_y <= ny;
        end
      end
      if (cmd.wr == owo_pkg::WR_PX && !func_q) pose_x <= pose_sat;
      if (cmd.wr == owo_pkg::WR_PY && !func_q) pose_y <= pose_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q <= func;
      stop_q <= stop;
      dsum <= -(27'(wheel_delta_0) + 27'(wheel_delta_1) + 27'(wheel_delta_2)
                + 27'(wheel_delta_3));
      ex <= 25'(wheel_delta_0) - 25'(wheel_delta_2);
      ey <= 25'(wheel_delta_3) - 25'(wheel_delta_1);
      vx <= goal_vx;
      vy <= goal_vy;
      wz <= goal_wz;
      nx <= new_x;
      ny <= new_y;
      nh <= new_heading[15:0];
    end
    prod <= mul_p[59:0];
    case (cmd.acc_op)
      owo_pkg::ACC_LOAD: acc <= 44'(prod);
      owo_pkg::ACC_ADD: acc <= acc + 44'(prod);
      owo_pkg::ACC_SUB: acc <= acc - 44'(prod);
      default: acc <= acc;
    endcase
    if (cmd.wr == owo_pkg::WR_SIN) sin_v <= tval;
    if (cmd.wr == owo_pkg::WR_COS) cos_v <= tval;
    if (cmd.wr == owo_pkg::WR_RV) rv <= acc[41:0];
    if (cmd.wr == owo_pkg::WR_KY) ky <= prod;
    if (cmd.wr == owo_pkg::WR_KX) kx <= prod;
    if (cmd.wr == owo_pkg::WR_GOAL) goal[cmd.wheel] <= w_sat;
    if (cmd.wr == owo_pkg::WR_OUT) begin
      pose_x_out <= pose_x;
      pose_y_out <= pose_y;
      heading_out <= heading;
      wheel_goal_0 <= goal[0];
      wheel_goal_1 <= goal[1];
      wheel_goal_2 <= goal[2];
      wheel_goal_3 <= w_sat;
    end
  end

endmodule

// ===== design/omni_wheel_odometry_and_mixing_unit.sv =====
// Top level of the omni wheel odometry and wheel goal mixing unit.
//  channel | signals                      | beat when
//  in      | in_valid, in_ready, fields   | in_valid && in_ready
//  out     | out_valid, out_ready, fields | out_valid && out_ready
//  cfg     | cfg_wr_en, cfg_wr_data       | cfg_wr_en
// Each item is worked through by the single shared multiplier, stepping through the
// heading, pose and mixing products in turn; a new item is taken only when idle.
// A finished result sits in the output register; the next item is taken at once.
// A new result waits only while the previous one is still unclaimed.
// Synchronous reset: pose zero, heading pi, angle_gain to its default.
module omni_wheel_odometry_and_mixing_unit #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic               cfg_wr_en,
  input  logic [23:0]        cfg_wr_data,
  input  logic               func,
  input  logic signed [23:0] wheel_delta_0,
  input  logic signed [23:0] wheel_delta_1,
  input  logic signed [23:0] wheel_delta_2,
  input  logic signed [23:0] wheel_delta_3,
  input  logic signed [23:0] goal_vx,
  input  logic signed [23:0] goal_vy,
  input  logic signed [23:0] goal_wz,
  input  logic               stop,
  input  logic signed [31:0] new_x,
  input  logic signed [31:0] new_y,
  input  logic signed [16:0] new_heading,
  output logic signed [31:0] pose_x_out,
  output logic signed [31:0] pose_y_out,
  output logic signed [16:0] heading_out,
  output logic signed [23:0] wheel_goal_0,
  output logic signed [23:0] wheel_goal_1,
  output logic signed [23:0] wheel_goal_2,
  output logic signed [23:0] wheel_goal_3
);

  owo_pkg::cmd_t cmd;

  owo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  owo_dp #(
    .SineTableDepth (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .func          (func),
    .wheel_delta_0 (wheel_delta_0),
    .wheel_delta_1 (wheel_delta_1),
    .wheel_delta_2 (wheel_delta_2),
    .wheel_delta_3 (wheel_delta_3),
    .goal_vx       (goal_vx),
    .goal_vy       (goal_vy),
    .goal_wz       (goal_wz),
    .stop          (stop),
    .new_x         (new_x),
    .new_y         (new_y),
    .new_heading   (new_heading),
    .pose_x_out    (pose_x_out),
    .pose_y_out    (pose_y_out),
    .heading_out   (heading_out),
    .wheel_goal_0  (wheel_goal_0),
    .wheel_goal_1  (wheel_goal_1),
    .wheel_goal_2  (wheel_goal_2),
    .wheel_goal_3  (wheel_goal_3)
  );

endmodule

// ===== sim/tb_omni_wheel_odometry_and_mixing_unit.sv =====
// Self-checking testbench for the omni wheel odometry and wheel goal mixing unit.
module tb_omni_wheel_odometry_and_mixing_unit;

  typedef struct packed {
    logic               func;
    logic signed [23:0] d0, d1, d2, d3;
    logic signed [23:0] vx, vy, wz;
    logic               stop;
    logic signed [31:0] nx, ny;
    logic signed [16:0] nh;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] px, py;
    logic signed [16:0] hd;
    logic signed [23:0] g0, g1, g2, g3;
  } pose_goal_t;

  localparam logic signed [23:0] D_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] D_MIN = 24'sh800000;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic cfg_wr_en;
  logic [23:0] cfg_wr_data;
  logic func, stop;
  logic signed [23:0] wheel_delta_0, wheel_delta_1, wheel_delta_2, wheel_delta_3;
  logic signed [23:0] goal_vx, goal_vy, goal_wz;
  logic signed [31:0] new_x, new_y;
  logic signed [16:0] new_heading;
  logic signed [31:0] pose_x_out, pose_y_out;
  logic signed [16:0] heading_out;
  logic signed [23:0] wheel_goal_0, wheel_goal_1, wheel_goal_2, wheel_goal_3;

  always #5 clk = ~clk;

  omni_wheel_odometry_and_mixing_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .func(func),
    .wheel_delta_0(wheel_delta_0), .wheel_delta_1(wheel_delta_1),
    .wheel_delta_2(wheel_delta_2), .wheel_delta_3(wheel_delta_3),
    .goal_vx(goal_vx), .goal_vy(goal_vy), .goal_wz(goal_wz),
    .stop(stop), .new_x(new_x), .new_y(new_y), .new_heading(new_heading),
    .pose_x_out(pose_x_out), .pose_y_out(pose_y_out), .heading_out(heading_out),
    .wheel_goal_0(wheel_goal_0), .wheel_goal_1(wheel_goal_1),
    .wheel_goal_2(wheel_goal_2), .wheel_goal_3(wheel_goal_3)
  );

  // predictor state
  logic [16:0] quarter_wave [0:256];
  logic [23:0] gain_m;
  int          px_m, py_m, hd_m;

  pose_goal_t pending_q [$];
  tick_t      rows_q [$];
  logic       rows_has [$];
  pose_goal_t rows_exp [$];
  int         errors = 0;
  int         beats_out = 0;
  int         loads_sent = 0;
  int         stops_sent = 0;
  logic       hold_req = 1'b0;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int wrap_bau(longint a);
    int r;
    r = int'(a & 64'hFFFF);
    if (r > 32768) r -= 65536;
    return r;
  endfunction

  function automatic longint sin_bau(longint a);
    int u, q, i;
    longint v;
    u = int'(a & 64'hFFFF);
    q = u >> 14;
    i = ((u & 16383) * 256) >> 14;
    v = (q & 1) ? longint'(quarter_wave[256 - i]) : longint'(quarter_wave[i]);
    return (q & 2) ? -v : v;
  endfunction

  task automatic build_quarter_wave();
    logic [63:0] x, term;
    longint acc;
    for (int k = 0; k <= 256; k++) begin
      x = 64'd1686629713 * 64'(k) / 64'd256;
      term = x;
      acc = longint'(x);
      for (int n = 1; n < 24; n++) begin
        if (term != 64'd0) begin
          term = ((((term * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) acc -= longint'(term);
          else acc += longint'(term);
        end
      end
      if (acc < 0) acc = 0;
      acc = (acc + 8192) >>> 14;
      quarter_wave[k] = (acc > 65536) ? 17'd65536 : acc[16:0];
    end
  endtask

  function automatic pose_goal_t predict_pose_goal(tick_t t);
    pose_goal_t r;
    longint s, c, ex, ey, rvx, rvy, wzs, dth;
    longint w [4];
    if (t.func) begin
      px_m = t.nx;
      py_m = t.ny;
      hd_m = wrap_bau(longint'(t.nh));
      s = sin_bau(hd_m);
      c = sin_bau(hd_m + 16384);
    end else begin
      dth = rnd_shift(-(longint'(t.d0) + t.d1 + t.d2 + t.d3) * longint'(gain_m), 24);
      ex = longint'(t.d0) - t.d2;
      ey = longint'(t.d3) - t.d1;
      hd_m = wrap_bau(hd_m + dth);
      s = sin_bau(hd_m);
      c = sin_bau(hd_m + 16384);
      px_m = int'(sat(px_m + rnd_shift(ex * c - ey * s, 17),
                      -64'sd2147483648, 64'sd2147483647));
      py_m = int'(sat(py_m + rnd_shift(ex * s + ey * c, 17),
                      -64'sd2147483648, 64'sd2147483647));
    end
    rvx = (longint'(t.vx) * c - longint'(t.vy) * s) * 46341;
    rvy = (longint'(t.vx) * s + longint'(t.vy) * c) * 46341;
    wzs = longint'(t.wz) <<< 32;
    w[0] = rvx - rvy - wzs;
    w[1] = -rvx - rvy - wzs;
    w[2] = -rvx + rvy - wzs;
    w[3] = rvx + rvy - wzs;
    for (int j = 0; j < 4; j++)
      w[j] = t.stop ? 0 : sat(rnd_shift(w[j], 32), -8388608, 8388607);
    r.px = px_m;
    r.py = py_m;
    r.hd = hd_m[16:0];
    r.g0 = w[0][23:0];
    r.g1 = w[1][23:0];
    r.g2 = w[2][23:0];
    r.g3 = w[3][23:0];
    return r;
  endfunction

  function automatic logic signed [23:0] rand_d24(int wide);
    int k;
    k = $urandom_range(0, 9);
    if (wide && k < 3) return 24'($urandom());
    if (k == 9) return $urandom_range(0, 1) ? D_MAX : D_MIN;
    return 24'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.func = ($urandom_range(0, 9) == 0);
    t.d0 = rand_d24(1);
    t.d1 = rand_d24(1);
    t.d2 = rand_d24(1);
    t.d3 = rand_d24(1);
    t.vx = rand_d24(1);
    t.vy = rand_d24(1);
    t.wz = rand_d24(1);
    t.stop = ($urandom_range(0, 4) == 0);
    t.nx = $urandom();
    t.ny = $urandom();
    t.nh = 17'($urandom());
    return t;
  endfunction

  function automatic tick_t mk(logic f, logic signed [23:0] a, b, cc, d,
                               logic signed [23:0] vx, vy, wz, logic st,
                               logic signed [31:0] nx, ny, logic signed [16:0] nh);
    tick_t t;
    t = '{func: f, d0: a, d1: b, d2: cc, d3: d, vx: vx, vy: vy, wz: wz,
          stop: st, nx: nx, ny: ny, nh: nh};
    return t;
  endfunction

  function automatic pose_goal_t mkr(logic signed [31:0] px, py, logic signed [16:0] hd);
    pose_goal_t r;
    r = '{px: px, py: py, hd: hd, g0: '0, g1: '0, g2: '0, g3: '0};
    return r;
  endfunction

  task automatic add_row(tick_t t, logic has, pose_goal_t r);
    rows_q.push_back(t);
    rows_has.push_back(has);
    rows_exp.push_back(r);
  endtask

  task automatic send_tick(tick_t t, logic has, pose_goal_t r);
    pose_goal_t p;
    in_valid <= 1'b1;
    func <= t.func;
    wheel_delta_0 <= t.d0;
    wheel_delta_1 <= t.d1;
    wheel_delta_2 <= t.d2;
    wheel_delta_3 <= t.d3;
    goal_vx <= t.vx;
    goal_vy <= t.vy;
    goal_wz <= t.wz;
    stop <= t.stop;
    new_x <= t.nx;
    new_y <= t.ny;
    new_heading <= t.nh;
    do @(posedge clk); while (!in_ready);
    p = predict_pose_goal(t);
    pending_q.push_back(has ? r : p);
    loads_sent += t.func;
    stops_sent += t.stop;
  endtask

  int burst_left = 4;
  task automatic maybe_gap();
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_gain(logic [23:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    gain_m = v;
    cfg_wr_en <= 1'b0;
  endtask

  // receiver: stall pattern plus one long hold-off
  initial begin
    int mode, cnt;
    cnt = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end
      if (cnt == 0) begin
        mode = $urandom_range(0, 3);
        cnt = $urandom_range(16, 96);
      end
      cnt--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    pose_goal_t e, a;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      a = '{px: pose_x_out, py: pose_y_out, hd: heading_out, g0: wheel_goal_0,
            g1: wheel_goal_1, g2: wheel_goal_2, g3: wheel_goal_3};
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %p", a);
      end else begin
        e = pending_q.pop_front();
        if (e !== a) begin
          errors++;
          if (errors <= 10) $display("mismatch beat %0d: expected %p actual %p", beats_out, e, a);
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("omni_wheel_odometry_and_mixing_unit regression: fail");
    $finish;
  end

  initial begin
    logic [23:0] gains [5];
    pose_goal_t none;
    none = '0;
    gains = '{24'hFFFFFF, 24'd0, 24'd547724, 24'd0, 24'd1};
    gains[3] = 24'($urandom());
    gains[4] = 24'($urandom());
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    func = 1'b0;
    stop = 1'b0;
    wheel_delta_0 = '0;
    wheel_delta_1 = '0;
    wheel_delta_2 = '0;
    wheel_delta_3 = '0;
    goal_vx = '0;
    goal_vy = '0;
    goal_wz = '0;
    new_x = '0;
    new_y = '0;
    new_heading = '0;
    build_quarter_wave();
    gain_m = 24'd547724;
    px_m = 0;
    py_m = 0;
    hd_m = 32768;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mkr(0, 0, 17'sd32768));
    add_row(mk(1, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, 0, 0, 1,
               32'sh7FFFFFFF, 32'sh80000000, 0), 1, mkr(32'sh7FFFFFFF, 32'sh80000000, 0));
    add_row(mk(1, 0, 0, 0, 0, D_MAX, D_MIN, D_MAX, 1, 0, 0, 17'h18000), 1,
            mkr(0, 0, 17'sd32768));
    add_row(mk(1, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 17'h10000), 1, mkr(0, 0, 0));
    add_row(mk(1, 0, 0, 0, 0, D_MAX, D_MIN, D_MAX, 0, 0, 0, 17'sd8192), 0, none);
    add_row(mk(1, 0, 0, 0, 0, D_MIN, D_MAX, D_MIN, 0, 0, 0, 17'sd32768), 0, none);
    add_row(mk(1, 0, 0, 0, 0, D_MAX, D_MAX, D_MIN, 0, 0, 0, 17'h1FFFF), 0, none);
    add_row(mk(0, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, D_MAX, 0, 0, 0, 0), 0, none);
    add_row(mk(0, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, D_MIN, 0, 0, 0, 0), 0, none);
    add_row(mk(0, 24'sd256, 24'sd512, -24'sd256, 24'sd1024, 24'sd2560, 0, 24'sd128,
               1, 0, 0, 0), 0, none);
    add_row(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 32'sh7FFF0000, 32'sh80010000, 0), 0, none);
    for (int k = 0; k < 4; k++)
      add_row(mk(0, D_MAX, D_MAX, D_MIN, D_MIN, 24'sd100, -24'sd100, 0, 0, 0, 0, 0), 0, none);
    for (int k = 0; k < 4; k++)
      add_row(mk(0, D_MIN, D_MAX, D_MAX, D_MIN, 0, 24'sd7, 24'sd1, 0, 0, 0, 0), 0, none);
    add_row(mk(0, -24'sd1, 0, 0, 0, 24'sd1, 24'sd1, -24'sd1, 0, 0, 0, 0), 0, none);
    add_row(mk(0, 24'sd1, 0, 0, 0, -24'sd1, -24'sd1, 24'sd1, 0, 0, 0, 0), 0, none);
    for (int k = 0; k < rows_q.size(); k++) begin
      send_tick(rows_q[k], rows_has[k], rows_exp[k]);
      maybe_gap();
    end

    for (int ph = 0; ph < 5; ph++) begin
      write_gain(gains[ph]);
      if (ph == 2) hold_req = 1'b1;
      for (int k = 0; k < 370; k++) begin
        send_tick(rand_tick(), 0, none);
        maybe_gap();
      end
    end
    drain();
    repeat (40) @(posedge clk);
    $display("ran %0d directed and 1850 random ticks, %0d loads, %0d stops, %0d results",
             rows_q.size(), loads_sent, stops_sent, beats_out);
    $display("angle gain swept over zero, full scale, default and random values");
    if (errors == 0) begin
      $display("omni_wheel_odometry_and_mixing_unit regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("omni_wheel_odometry_and_mixing_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/owo_pkg.sv
design/owo_ctrl.sv
design/owo_dp.sv
design/omni_wheel_odometry_and_mixing_unit.sv
sim/tb_omni_wheel_odometry_and_mixing_unit.sv
